/* rtl/mf3_pkg.sv */
// ----------------------------------------------------------------------------
// mf3_pkg
// shared types and constants of the 3x3 median filter with edge replication
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_DW      = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int WIN_SIZE    = 9;
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_HEIGHT = 2'd1;

    // item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    // nine window values handed to the median sorter
    typedef logic [WIN_SIZE-1:0][PIX_W-1:0] t_win9;

    // classified item, passed from the front to the back
    typedef struct packed {
        logic row0;      // first row: whole column replicates the pixel
        logic row1;      // second row: top replicates the middle line
        logic draining;  // past the last row: bottom replicates the middle line
        logic shift;     // new column enters the window
        logic write;     // line stores take this column
        logic emit;      // item yields a result
        logic pre;       // result is the right edge of the previous row
        logic left_dup;  // left column replicates its neighbour
        logic last;      // result ends the frame
    } t_op;

endpackage

/* rtl/mf3_front.sv */
// ----------------------------------------------------------------------------
// mf3_front
// accepts items, tracks input and output positions, classifies each item
// ----------------------------------------------------------------------------
module mf3_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mf3_pkg::CFG_DW-1:0]          i_cfg_data,
    input  logic                                i_valid,
    input  logic                                i_kind,
    input  mf3_pkg::t_pix                       i_pixel,
    input  logic                                i_full,
    output logic                                o_ready,
    output logic                                o_push,
    output mf3_pkg::t_op                        o_op,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_col,
    output mf3_pkg::t_pix                       o_pixel
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int W_RST = (512 > MAX_WIDTH) ? MAX_WIDTH : 512;
    localparam int H_RST = (512 > MAX_HEIGHT) ? MAX_HEIGHT : 512;

    logic [CW-1:0] r_w, n_w;
    logic [HW-1:0] r_h, n_h;
    logic [CW-1:0] r_in_col, n_in_col;
    logic [RW-1:0] r_in_row, n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;

    logic          accept, draining, drop, due, at_end, cfg_hit;
    mf3_pkg::t_op op;

    // clamp of register writes to the supported range
    always_comb begin
        n_w = r_w;
        n_h = r_h;
        cfg_hit = 1'b0;
        if (i_cfg_valid && i_cfg_index == mf3_pkg::CFG_IDX_FRAME_WIDTH) begin
            cfg_hit = 1'b1;
            if (i_cfg_data == '0) begin
                n_w = CW'(1);
            end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
                n_w = CW'(MAX_WIDTH);
            end else begin
                n_w = CW'(i_cfg_data);
            end
        end
        if (i_cfg_valid && i_cfg_index == mf3_pkg::CFG_IDX_FRAME_HEIGHT) begin
            cfg_hit = 1'b1;
            if (i_cfg_data == '0) begin
                n_h = HW'(1);
            end else if (32'(i_cfg_data) > 32'(MAX_HEIGHT)) begin
                n_h = HW'(MAX_HEIGHT);
            end else begin
                n_h = HW'(i_cfg_data);
            end
        end
    end

    always_comb begin
        accept   = i_valid && o_ready;
        draining = r_in_row >= RW'(r_h);
        drop     = !draining && (i_kind == mf3_pkg::KIND_DRAIN);
        due      = (r_in_row >= RW'(2)) || (r_in_row == RW'(1) && r_in_col != '0);
        at_end   = (r_out_row >= RW'(r_h - 1'b1)) && (r_out_col >= r_w - 1'b1);

        op.row0     = r_in_row == '0;
        op.row1     = r_in_row == RW'(1);
        op.draining = draining;
        op.emit     = due;
        op.pre      = due && r_in_col == '0;
        op.last     = due && at_end;
        op.shift    = !(op.pre && op.last);
        op.write    = op.shift && !draining;
        op.left_dup = op.pre ? (r_w == CW'(1)) : (r_in_col == CW'(1));

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (accept && !drop) begin
            if (op.last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                if (op.emit) begin
                    if (r_out_col + 1'b1 >= r_w) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + 1'b1;
                    end else begin
                        n_out_col = r_out_col + 1'b1;
                    end
                end
                if (r_in_col + 1'b1 >= r_w) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + 1'b1;
                end else begin
                    n_in_col = r_in_col + 1'b1;
                end
            end
        end
        // a register write restarts the frame
        if (cfg_hit) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= CW'(W_RST);
            r_h       <= HW'(H_RST);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_w       <= n_w;
            r_h       <= n_h;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    assign o_ready = !i_full;
    assign o_push  = accept && !drop;
    assign o_op    = op;
    assign o_col   = r_in_col[AW-1:0];
    assign o_pixel = i_pixel;

endmodule

/* rtl/mf3_fifo.sv */
// ----------------------------------------------------------------------------
// mf3_fifo
// short queue of classified items between the front and the back
// ----------------------------------------------------------------------------
module mf3_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [NW-1:0]     r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = r_count == NW'(DEPTH);
    assign o_empty = r_count == '0;

endmodule

/* rtl/mf3_median.sv */
// ----------------------------------------------------------------------------
// mf3_median
// three stage median of nine: sort triples, combine, final median of three
// ----------------------------------------------------------------------------
module mf3_median (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  mf3_pkg::t_win9 i_vals,
    input  logic           i_last,
    output logic           o_valid,
    output mf3_pkg::t_pix  o_value,
    output logic           o_last
);

    function automatic mf3_pkg::t_pix min2(mf3_pkg::t_pix a, mf3_pkg::t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic mf3_pkg::t_pix max2(mf3_pkg::t_pix a, mf3_pkg::t_pix b);
        return (a < b) ? b : a;
    endfunction

    function automatic mf3_pkg::t_pix med3(mf3_pkg::t_pix a, mf3_pkg::t_pix b,
                                           mf3_pkg::t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    mf3_pkg::t_pix r_lo [3];
    mf3_pkg::t_pix r_mi [3];
    mf3_pkg::t_pix r_hi [3];
    mf3_pkg::t_pix r_a, r_b, r_c, r_med;
    logic          r_v1, r_v2, r_v3;
    logic          r_l1, r_l2, r_l3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int g = 0; g < 3; g++) begin
                r_lo[g] <= min2(min2(i_vals[3*g], i_vals[3*g+1]), i_vals[3*g+2]);
                r_mi[g] <= med3(i_vals[3*g], i_vals[3*g+1], i_vals[3*g+2]);
                r_hi[g] <= max2(max2(i_vals[3*g], i_vals[3*g+1]), i_vals[3*g+2]);
            end
            r_l1  <= i_last;
            r_a   <= max2(max2(r_lo[0], r_lo[1]), r_lo[2]);
            r_b   <= med3(r_mi[0], r_mi[1], r_mi[2]);
            r_c   <= min2(min2(r_hi[0], r_hi[1]), r_hi[2]);
            r_l2  <= r_l1;
            r_med <= med3(r_a, r_b, r_c);
            r_l3  <= r_l2;
        end
    end

    assign o_valid = r_v3;
    assign o_value = r_med;
    assign o_last  = r_l3;

endmodule

/* rtl/mf3_back.sv */
// ----------------------------------------------------------------------------
// mf3_back
// line stores, 3x3 window and median pipeline with the output register
// ----------------------------------------------------------------------------
module mf3_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  mf3_pkg::t_op                 i_op,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_col,
    input  mf3_pkg::t_pix                i_pixel,
    input  logic                         i_out_ready,
    output logic                         o_pop,
    output logic                         o_valid,
    output mf3_pkg::t_pix                o_value,
    output logic                         o_last
);

    localparam int AW = $clog2(MAX_WIDTH);

    mf3_pkg::t_pix  r_upper_mem  [MAX_WIDTH];
    mf3_pkg::t_pix  r_middle_mem [MAX_WIDTH];
    mf3_pkg::t_pix  r_rd_u, r_rd_m;
    logic           r_fwd;
    mf3_pkg::t_pix  r_fwd_u, r_fwd_m;

    logic           r_b_valid;
    mf3_pkg::t_op   r_b_op;
    logic [AW-1:0]  r_b_col;
    mf3_pkg::t_pix  r_b_pix;

    mf3_pkg::t_pix  r_win [3][3];
    mf3_pkg::t_pix  n_win [3][3];
    mf3_pkg::t_pix  col_v [3];
    mf3_pkg::t_pix  u_val, m_val;
    mf3_pkg::t_win9 sel;

    logic           adv, b_wr;
    logic           med_valid, med_last;
    mf3_pkg::t_pix  med_value;
    logic           r_out_valid, r_out_last;
    mf3_pkg::t_pix  r_out_value;

    assign adv   = !r_out_valid || i_out_ready;
    assign o_pop = adv && !i_empty;
    assign b_wr  = r_b_valid && r_b_op.write;

    always_comb begin
        m_val = r_fwd ? r_fwd_m : r_rd_m;
        u_val = r_fwd ? r_fwd_u : r_rd_u;
        if (r_b_op.row0) begin
            col_v[0] = r_b_pix;
            col_v[1] = r_b_pix;
            col_v[2] = r_b_pix;
        end else begin
            col_v[0] = r_b_op.row1 ? m_val : u_val;
            col_v[1] = m_val;
            col_v[2] = r_b_op.draining ? m_val : r_b_pix;
        end
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = r_win[i][1];
            n_win[i][1] = r_win[i][2];
            n_win[i][2] = col_v[i];
        end
        for (int i = 0; i < 3; i++) begin
            if (r_b_op.pre) begin
                sel[3*i]   = r_b_op.left_dup ? r_win[i][2] : r_win[i][1];
                sel[3*i+1] = r_win[i][2];
                sel[3*i+2] = r_win[i][2];
            end else begin
                sel[3*i]   = r_b_op.left_dup ? n_win[i][1] : n_win[i][0];
                sel[3*i+1] = n_win[i][1];
                sel[3*i+2] = n_win[i][2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_fwd     <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (adv) begin
            r_b_valid <= o_pop;
            if (o_pop) begin
                r_b_op  <= i_op;
                r_b_col <= i_col;
                r_b_pix <= i_pixel;
                // same address written by the item ahead in this cycle
                r_fwd   <= b_wr && (r_b_col == i_col);
                r_fwd_u <= m_val;
                r_fwd_m <= r_b_pix;
            end
            if (r_b_valid && r_b_op.shift) begin
                r_win <= n_win;
            end
        end
    end

    // line stores: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (adv && b_wr) begin
            r_upper_mem[r_b_col]  <= m_val;
            r_middle_mem[r_b_col] <= r_b_pix;
        end
        if (o_pop) begin
            r_rd_u <= r_upper_mem[i_col];
            r_rd_m <= r_middle_mem[i_col];
        end
    end

    mf3_median u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_b_valid && r_b_op.emit),
        .i_vals  (sel),
        .i_last  (r_b_op.last),
        .o_valid (med_valid),
        .o_value (med_value),
        .o_last  (med_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= med_valid;
            r_out_value <= med_value;
            r_out_last  <= med_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_last  = r_out_last;

endmodule

/* rtl/median_filter_3x3_replicate.sv */
// ----------------------------------------------------------------------------
// median_filter_3x3_replicate
// 3x3 median filter over a raster stream of 8-bit grey pixels, edge replicated
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: pixel, tuser: kind
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: median_value, tlast: frame_last
// cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// one item per cycle sustained while m_axis is not stalled; each line store takes one read and one write a cycle
// an accepted item reaches m_axis via the queue, the item register, the median stages and the output register
// synchronous active-low reset; line stores are not cleared, no start-up pass
// stalls on m_axis hold the whole back end; the four-entry queue then fills and
// drops s_axis_tready
//
module median_filter_3x3_replicate #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] pixel
    input  logic                              s_axis_tuser,   // [0] kind
    // results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,   // [7:0] median_value
    output logic                              m_axis_tlast,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mf3_pkg::CFG_DW-1:0]        i_cfg_data
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int OPW = $bits(mf3_pkg::t_op);
    localparam int FW  = OPW + mf3_pkg::PIX_W + AW;

    // front side
    logic          front_push;
    mf3_pkg::t_op  front_op;
    logic [AW-1:0] front_col;
    mf3_pkg::t_pix front_pix;

    // queue
    logic [FW-1:0] fifo_data;
    logic          fifo_full, fifo_empty;

    // back side
    logic          back_pop;
    mf3_pkg::t_op  q_op;
    logic [AW-1:0] q_col;
    mf3_pkg::t_pix q_pix;

    // registers are taken in any cycle
    assign o_cfg_ready = 1'b1;

    mf3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_kind      (s_axis_tuser),
        .i_pixel     (s_axis_tdata),
        .i_full      (fifo_full),
        .o_ready     (s_axis_tready),
        .o_push      (front_push),
        .o_op        (front_op),
        .o_col       (front_col),
        .o_pixel     (front_pix)
    );

    // classified item: op flags low, then pixel, then column
    mf3_fifo #(
        .DATA_W (FW),
        .DEPTH  (mf3_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  ({front_col, front_pix, front_op}),
        .i_pop   (back_pop),
        .o_data  (fifo_data),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    assign q_op  = mf3_pkg::t_op'(fifo_data[OPW-1:0]);
    assign q_pix = fifo_data[OPW +: mf3_pkg::PIX_W];
    assign q_col = fifo_data[OPW + mf3_pkg::PIX_W +: AW];

    mf3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (fifo_empty),
        .i_op        (q_op),
        .i_col       (q_col),
        .i_pixel     (q_pix),
        .i_out_ready (m_axis_tready),
        .o_pop       (back_pop),
        .o_valid     (m_axis_tvalid),
        .o_value     (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

    // no item is queued into a full queue
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_push |-> !fifo_full)
        else $error("item queued while queue full");

    // a queued item is visible to the back end in the next cycle
    a_push_then_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_push |=> !fifo_empty)
        else $error("queue empty after push");

    // the back end only takes items that are there
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_pop |-> !fifo_empty)
        else $error("item taken from empty queue");

endmodule

/* tb/median_filter_3x3_replicate_test.sv */
// ----------------------------------------------------------------------------
// median_filter_3x3_replicate_test
// self-checking bench for the 3x3 edge-replicated median filter: a cycle-free
// model predicts every median and frame_last flag from the accepted items, and
// the results are checked in order while both stream sides idle and stall at
// random and frame sizes change between frames
// ----------------------------------------------------------------------------
module median_filter_3x3_replicate_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     MAX_COLS        = 1024;
    localparam int     MAX_ROWS        = 1024;
    localparam int     MID_RANK        = 4;       // fifth smallest of nine
    localparam int     RANDOM_PIXELS   = 450;
    localparam int     OVERSIZE_PIXELS = 16;      // part of a first row at clamped size
    localparam int     PRESSURE_PIXELS = 60;      // one-pixel rows, a result per item after the first two
    localparam int     SETTLE_CYCLES   = 30;      // long enough for the pipeline to empty
    localparam int     LONG_HOLD       = 400;     // receiver hold-off that backs up the input
    localparam longint CYCLE_LIMIT     = 1000000;

    // index with no register behind it, writes there change nothing
    localparam logic [mf3_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd2;

    typedef struct packed {
        logic          kind;
        mf3_pkg::t_pix pixel;
    } t_stream_item;

    typedef struct packed {
        mf3_pkg::t_pix median;
        logic          last;
    } t_median_out;

    // receiver ready patterns
    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    // ------------------------------------------------------------------------
    // clock, reset and block ports, the driven inputs all known from time zero
    // ------------------------------------------------------------------------
    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata  = '0;    // [7:0] pixel
    logic                          s_axis_tuser  = 1'b0;  // [0] kind
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [7:0]                    m_axis_tdata;          // [7:0] median_value
    logic                          m_axis_tlast;          // frame_last
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic [mf3_pkg::CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [mf3_pkg::CFG_DW-1:0]    i_cfg_data    = '0;

    always #6 i_clk = ~i_clk;

    median_filter_3x3_replicate #(
        .MAX_WIDTH (MAX_COLS),
        .MAX_HEIGHT(MAX_ROWS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // filter model state: two line stores, the 3x3 window (column 2 newest),
    // input and output raster positions and the two size registers
    // ------------------------------------------------------------------------
    mf3_pkg::t_pix              upper_store [MAX_COLS];
    mf3_pkg::t_pix              middle_store[MAX_COLS];
    mf3_pkg::t_pix              win         [mf3_pkg::WIN_SIZE];
    int unsigned                in_col, in_row, out_col, out_row;
    logic [mf3_pkg::CFG_DW-1:0] width_reg, height_reg;
    t_median_out                due_medians[$];          // medians still to come, oldest first

    // bench bookkeeping
    t_stream_item               pending_items[$];
    t_stream_item               next_item;
    int unsigned                items_queued  = 0;
    int unsigned                items_taken   = 0;
    int unsigned                random_pixels = 0;
    int unsigned                mismatches    = 0;
    longint                     cycle_count   = 0;
    bit                         in_fire       = 1'b0;   // an item went in at the last rising edge
    bit                         cfg_fire      = 1'b0;   // a register write went in at the last edge
    logic [mf3_pkg::CFG_DW-1:0] stim_width    = 11'd512;
    logic [mf3_pkg::CFG_DW-1:0] stim_height   = 11'd512;

    // sender bursts and receiver pattern
    int unsigned       burst_left = 0;
    int unsigned       gap_left   = 0;
    int unsigned       mode_left  = 0;
    int unsigned       hold_left  = 0;
    int unsigned       rx_phase   = 0;
    t_rx_mode          ready_mode = RX_FREE;
    bit                hold_request = 1'b0;
    bit                hold_served  = 1'b0;

    // zero acts as one, oversize acts as the maximum
    function automatic int unsigned effective_size(logic [mf3_pkg::CFG_DW-1:0] v,
                                                   int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic void restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void reset_model();
        foreach (upper_store[i]) begin
            upper_store[i]  = '0;
            middle_store[i] = '0;
        end
        foreach (win[i]) win[i] = '0;
        restart_frame();
        width_reg  = 11'd512;
        height_reg = 11'd512;
    endfunction

    // median over window columns lc, cc and rc of all three rows
    function automatic mf3_pkg::t_pix window_median(int lc, int cc, int rc);
        mf3_pkg::t_pix v[mf3_pkg::WIN_SIZE];
        mf3_pkg::t_pix x;
        int            j;
        for (int i = 0; i < 3; i++) begin
            v[i * 3]     = win[i * 3 + lc];
            v[i * 3 + 1] = win[i * 3 + cc];
            v[i * 3 + 2] = win[i * 3 + rc];
        end
        for (int i = 1; i < mf3_pkg::WIN_SIZE; i++) begin
            x = v[i];
            j = i;
            while (j > 0 && v[j - 1] > x) begin
                v[j] = v[j - 1];
                j--;
            end
            v[j] = x;
        end
        return v[MID_RANK];
    endfunction

    // queue one median, advance the output position; true when it ends the frame
    function automatic bit push_median(mf3_pkg::t_pix value, int unsigned w, int unsigned h);
        bit last;
        last = (out_row + 1 >= h) && (out_col + 1 >= w);
        due_medians.push_back('{median: value, last: last});
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        if (last) restart_frame();
        return last;
    endfunction

    // one accepted item through the filter, zero or one median out
    task automatic median_step(input logic kind, input mf3_pkg::t_pix pixel);
        int unsigned   w, h, c, r;
        bit            draining, due;
        mf3_pkg::t_pix u, m, top, mid, bot;
        w        = effective_size(width_reg, MAX_COLS);
        h        = effective_size(height_reg, MAX_ROWS);
        c        = in_col;
        r        = in_row;
        draining = (r >= h);
        due      = (r >= 2) || (r == 1 && c >= 1);

        // drain tick inside the frame: ignored
        if (!draining && kind == mf3_pkg::KIND_DRAIN) return;

        // right edge of the previous row goes out before the new column enters
        if (due && c == 0) begin
            if (push_median(window_median((w == 1) ? 2 : 1, 2, 2), w, h)) return;
        end

        u = upper_store[c];
        m = middle_store[c];
        if (r == 0) begin
            // first row: top and bottom replicate the pixel itself
            top = pixel;
            mid = pixel;
            bot = pixel;
        end else begin
            top = (r == 1) ? m : u;
            mid = m;
            bot = draining ? m : pixel;   // past the last row the bottom replicates
        end
        for (int i = 0; i < 3; i++) begin
            win[i * 3]     = win[i * 3 + 1];
            win[i * 3 + 1] = win[i * 3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = bot;

        if (!draining) begin
            upper_store[c]  = m;
            middle_store[c] = pixel;
        end

        // left column replicated at the start of a row
        if (due && c >= 1) begin
            if (push_median(window_median((c == 1) ? 1 : 0, 1, 2), w, h)) return;
        end

        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
    endtask

    // ------------------------------------------------------------------------
    // monitor: everything sampled at the rising edge, before the block updates
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_median_out want;
        in_fire  <= i_rst_n && s_axis_tvalid && s_axis_tready;
        cfg_fire <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    mf3_pkg::CFG_IDX_FRAME_WIDTH: begin
                        width_reg = i_cfg_data;
                        restart_frame();
                    end
                    mf3_pkg::CFG_IDX_FRAME_HEIGHT: begin
                        height_reg = i_cfg_data;
                        restart_frame();
                    end
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                median_step(s_axis_tuser, s_axis_tdata);
                items_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_medians.size() == 0) begin
                    $error("median_value: no result expected, actual %0d", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = due_medians.pop_front();
                    if (m_axis_tdata !== want.median) begin
                        $error("median_value: expected %0d, actual %0d",
                               want.median, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("frame_last: expected %0d, actual %0d",
                               want.last, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender: bursts of random length with random gaps, some gaps empty so
    // whole bursts run back to back at full rate
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (gap_left != 0) begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                next_item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_item.pixel;
                s_axis_tuser  <= next_item.kind;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: ready pattern changes now and then at random; one long hold-off
    // on request fills the block so that it drops s_axis_tready
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        rx_phase <= rx_phase + 1;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_request && !hold_served) begin
            hold_served   <= 1'b1;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left  <= $urandom_range(20, 200);
                ready_mode <= t_rx_mode'($urandom_range(0, 3));
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                RX_FREE:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= (rx_phase % 5 < 2);
            endcase
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers, all timed on the falling edge
    // ------------------------------------------------------------------------
    task automatic queue_item(input logic kind, input mf3_pkg::t_pix pixel);
        pending_items.push_back('{kind: kind, pixel: pixel});
        items_queued++;
    endtask

    // all items in, all medians out, then let the pipeline settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (items_taken != items_queued || due_medians.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [mf3_pkg::CFG_IDX_W-1:0] index,
                             input logic [mf3_pkg::CFG_DW-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(negedge i_clk);
        while (!cfg_fire);
        i_cfg_valid <= 1'b0;
        if (index == mf3_pkg::CFG_IDX_FRAME_WIDTH) stim_width = value;
        else if (index == mf3_pkg::CFG_IDX_FRAME_HEIGHT) stim_height = value;
    endtask

    // one frame at the current size; a broken frame ends with too few drain
    // ticks, so the next frame's first pixels are eaten as drain ticks
    task automatic queue_frame(input bit broken);
        int unsigned   w, h, drains;
        mf3_pkg::t_pix lo, hi;
        w = effective_size(stim_width, MAX_COLS);
        h = effective_size(stim_height, MAX_ROWS);
        // narrow value band now and then for plenty of ties
        if ($urandom_range(0, 2) == 0) begin
            lo = $urandom_range(0, 250);
            hi = lo + 8'd5;
        end else begin
            lo = 8'd0;
            hi = 8'd255;
        end
        for (int p = 0; p < w * h; p++) begin
            // stray drain tick inside the frame, must be ignored
            if ($urandom_range(0, 19) == 0) begin
                queue_item(mf3_pkg::KIND_DRAIN, $urandom_range(0, 255));
            end
            queue_item(mf3_pkg::KIND_PIXEL, $urandom_range(hi, lo));
        end
        drains = broken ? $urandom_range(0, w) : w + 1;
        for (int d = 0; d < drains; d++) begin
            // a pixel while draining counts as a drain tick
            queue_item(($urandom_range(0, 4) == 0) ? mf3_pkg::KIND_PIXEL : mf3_pkg::KIND_DRAIN,
                       $urandom_range(0, 255));
        end
    endtask

    // mostly small frames, sizes changed between frames half the time
    task automatic random_frames(input int unsigned target);
        int unsigned pick, w, h;
        while (random_pixels < target) begin
            if ($urandom_range(0, 1) == 0) begin
                pick = $urandom_range(0, 9);
                w = (pick == 0) ? 0 : (pick <= 6) ? $urandom_range(1, 8) :
                    (pick <= 8) ? $urandom_range(9, 32) : $urandom_range(33, 80);
                pick = $urandom_range(0, 9);
                h = (pick == 0) ? 0 : (w > 8) ? $urandom_range(1, 3) :
                    (pick <= 8) ? $urandom_range(1, 6) : $urandom_range(7, 16);
                wait_idle();
                pick = $urandom_range(0, 2);
                if (pick != 1) write_reg(mf3_pkg::CFG_IDX_FRAME_WIDTH, w);
                if (pick != 0) write_reg(mf3_pkg::CFG_IDX_FRAME_HEIGHT, h);
            end
            queue_frame($urandom_range(0, 9) == 0);
            random_pixels += effective_size(stim_width, MAX_COLS)
                           * effective_size(stim_height, MAX_ROWS);
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        mf3_pkg::t_pix corner_px[9];
        corner_px = '{8'd0, 8'd255, 8'd17, 8'd200, 8'd1, 8'd128, 8'd255, 8'd0, 8'd64};

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 frame with extreme pixels, a stray drain tick inside the frame
        // and a pixel among the drain ticks
        write_reg(mf3_pkg::CFG_IDX_FRAME_WIDTH, 11'd3);
        write_reg(mf3_pkg::CFG_IDX_FRAME_HEIGHT, 11'd3);
        for (int i = 0; i < 9; i++) begin
            queue_item(mf3_pkg::KIND_PIXEL, corner_px[i]);
            if (i == 1) queue_item(mf3_pkg::KIND_DRAIN, 8'hFF);
        end
        queue_item(mf3_pkg::KIND_DRAIN, 8'h00);
        queue_item(mf3_pkg::KIND_PIXEL, 8'hAA);
        queue_item(mf3_pkg::KIND_DRAIN, 8'h55);
        queue_item(mf3_pkg::KIND_DRAIN, 8'hFF);
        wait_idle();

        // write to an unused index, then zero sizes acting as a 1x1 frame
        write_reg(CFG_IDX_SPARE, 11'h7FF);
        write_reg(mf3_pkg::CFG_IDX_FRAME_WIDTH, 11'd0);
        write_reg(mf3_pkg::CFG_IDX_FRAME_HEIGHT, 11'd0);
        queue_item(mf3_pkg::KIND_PIXEL, 8'h5A);
        queue_item(mf3_pkg::KIND_DRAIN, 8'h00);
        queue_item(mf3_pkg::KIND_DRAIN, 8'h00);
        wait_idle();

        // size write in the middle of a frame restarts it, stores are kept
        write_reg(mf3_pkg::CFG_IDX_FRAME_WIDTH, 11'd2);
        write_reg(mf3_pkg::CFG_IDX_FRAME_HEIGHT, 11'd3);
        queue_item(mf3_pkg::KIND_PIXEL, 8'h10);
        queue_item(mf3_pkg::KIND_PIXEL, 8'hF0);
        queue_item(mf3_pkg::KIND_PIXEL, 8'h0F);
        queue_item(mf3_pkg::KIND_PIXEL, 8'h80);
        wait_idle();
        write_reg(mf3_pkg::CFG_IDX_FRAME_HEIGHT, 11'd2);
        queue_frame(1'b0);

        random_frames(RANDOM_PIXELS / 2);

        // oversize sizes clamp to the maximum; part of a first row gives
        // no results
        wait_idle();
        write_reg(mf3_pkg::CFG_IDX_FRAME_WIDTH, 11'h7FF);
        write_reg(mf3_pkg::CFG_IDX_FRAME_HEIGHT, 11'h7FF);
        for (int i = 0; i < OVERSIZE_PIXELS; i++) begin
            queue_item(mf3_pkg::KIND_PIXEL, $urandom_range(0, 255));
        end
        wait_idle();

        // one-pixel rows under the clamped height give a result per item past the
        // first two rows, so the long receiver hold-off backs the block up here
        write_reg(mf3_pkg::CFG_IDX_FRAME_WIDTH, 11'd1);
        hold_request = 1'b1;
        for (int i = 0; i < PRESSURE_PIXELS; i++) begin
            queue_item(mf3_pkg::KIND_PIXEL, $urandom_range(0, 255));
        end
        wait_idle();

        // back to a small frame before the second random stretch
        write_reg(mf3_pkg::CFG_IDX_FRAME_WIDTH, 11'd4);
        write_reg(mf3_pkg::CFG_IDX_FRAME_HEIGHT, 11'd3);

        random_frames(RANDOM_PIXELS);

        wait_idle();
        if (mismatches == 0 && due_medians.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/mf3_pkg.sv
rtl/mf3_front.sv
rtl/mf3_fifo.sv
rtl/mf3_median.sv
rtl/mf3_back.sv
rtl/median_filter_3x3_replicate.sv
tb/median_filter_3x3_replicate_test.sv
